>>> src/ped_pkg.sv
// ============================================================================
// ped_pkg: shared types and constants for the percent-escape decoder
// Request structs, escape phase encoding and hex digit decode.
// ============================================================================
package ped_pkg;

    // Input request: one byte of the escaped string.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Output request: one byte of the decoded string.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // Escape phase.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,   // no escape pending
        PH_PCT   = 2'd1,   // '%' seen
        PH_DIGIT = 2'd2    // '%' and first hex digit seen
    } t_phase;

    // Most output bytes that one input byte can produce.
    localparam int unsigned MAX_EMIT = 3;

    // Output queue geometry.
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    // Characters.
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [3:0] NIB_10 = 4'd10;

    // Hex decode: returns {is_hex, nibble}.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA;
            r = {1'b1, NIB_10 + d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA;
            r = {1'b1, NIB_10 + d[3:0]};
        end
        return r;
    endfunction

endpackage

>>> src/percent_escape_decoder_top.sv
// ============================================================================
// percent_escape_decoder_top: lenient URL percent-escape decoder
// Decoded bytes are registered in the output queue and offered from there.
// Throughput: one input request per cycle while at least 3 of the 8 queue slots are free.
// Reset (synchronous, i_rst_n low): no escape pending, output queue empty.
// ============================================================================
module percent_escape_decoder_top
    import ped_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // input channel
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    // output channel
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // ------------------------------------------------------------------------
    // Escape state
    // ------------------------------------------------------------------------
    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;      // first hex digit character
    logic [3:0] r_nib, n_nib;        // its value

    // Phase after the byte itself, before any end-of-string flush.
    t_phase     w_mid_phase;

    logic [4:0] w_hex;
    logic       w_is_hex;
    logic       w_is_pct;

    // Decoded bytes for this request (0 to MAX_EMIT of them).
    t_out       e_data [MAX_EMIT];
    logic [1:0] e_n;

    // ------------------------------------------------------------------------
    // Output queue: decoded bytes wait here, so a burst of three bytes from
    // a broken escape never stalls the input side in steady state.
    // ------------------------------------------------------------------------
    t_out           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count, n_count;

    logic       w_in_acc;
    logic       w_pop;
    logic [1:0] w_push_n;

    assign w_hex    = hex_decode(i_data.in_byte);
    assign w_is_hex = w_hex[4];
    assign w_is_pct = (i_data.in_byte == CH_PCT);

    // Room for the worst case of three bytes must be free before accepting.
    assign o_stall  = (r_count > QCW'(QDEPTH - MAX_EMIT));
    assign w_in_acc = i_valid && !o_stall;

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign w_pop    = o_valid && !i_stall;

    assign w_push_n = w_in_acc ? e_n : 2'd0;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_held      = r_held;
        n_nib       = r_nib;
        w_mid_phase = PH_IDLE;
        unique case (r_phase)
            PH_PCT: begin
                if (!w_is_pct && w_is_hex) begin
                    n_held      = i_data.in_byte;
                    n_nib       = w_hex[3:0];
                    w_mid_phase = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                w_mid_phase = PH_IDLE;
            end
            default: begin
                if (w_is_pct) begin
                    w_mid_phase = PH_PCT;
                end
            end
        endcase
        // end of string: any pending escape is flushed, back to idle
        n_phase = i_data.in_last ? PH_IDLE : w_mid_phase;
    end

    // ------------------------------------------------------------------------
    // Emitted bytes
    // ------------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < MAX_EMIT; k++) begin
            e_data[k] = '0;
        end
        e_n = 2'd0;
        unique case (r_phase)
            PH_PCT: begin
                if (w_is_pct) begin
                    // "%%" gives a single '%'
                    e_data[0].out_byte = CH_PCT;
                    e_n = 2'd1;
                end else if (!w_is_hex) begin
                    // percent then a non-hex character: pass both on
                    e_data[0].out_byte = CH_PCT;
                    e_data[1].out_byte = i_data.in_byte;
                    e_n = 2'd2;
                end
            end
            PH_DIGIT: begin
                if (w_is_hex) begin
                    e_data[0].out_byte = {r_nib, w_hex[3:0]};
                    e_n = 2'd1;
                end else begin
                    // bad second digit: pass the whole sequence on
                    e_data[0].out_byte = CH_PCT;
                    e_data[1].out_byte = r_held;
                    e_data[2].out_byte = i_data.in_byte;
                    e_n = 2'd3;
                end
            end
            default: begin
                if (!w_is_pct) begin
                    e_data[0].out_byte = i_data.in_byte;
                    e_n = 2'd1;
                end
            end
        endcase

        if (i_data.in_last) begin
            // flush an unfinished escape literally
            if (w_mid_phase == PH_PCT) begin
                e_data[e_n].out_byte = CH_PCT;
                e_n = e_n + 2'd1;
            end else if (w_mid_phase == PH_DIGIT) begin
                e_data[e_n].out_byte = CH_PCT;
                e_data[e_n + 2'd1].out_byte = n_held;
                e_n = e_n + 2'd2;
            end
            if (e_n != 2'd0) begin
                e_data[e_n - 2'd1].out_last = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Queue bookkeeping
    // ------------------------------------------------------------------------
    assign n_count = r_count + QCW'(w_push_n) - QCW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_held   <= '0;
            r_nib    <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_acc) begin
                r_phase  <= n_phase;
                r_held   <= n_held;
                r_nib    <= n_nib;
                r_wr_ptr <= r_wr_ptr + QAW'(w_push_n);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // queue storage: up to three consecutive slots written per request
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int k = 0; k < MAX_EMIT; k++) begin
                if (2'(k) < e_n) begin
                    r_mem[r_wr_ptr + QAW'(k)] <= e_data[k];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("output queue overflow");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QAW-1:0])
        else $error("queue pointers disagree with count");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.in_last) |-> (e_n != 2'd0))
        else $error("end of string produced no byte");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_data.in_last) |=> (r_phase == PH_IDLE))
        else $error("escape left pending after end of string");
`endif

endmodule

>>> dv/percent_escape_decoder_top_tb.sv
// ============================================================================
// percent_escape_decoder_top_tb: self-checking bench for the escape decoder
// Runs a short directed table (plain bytes at the extremes, "%%", hex escapes
// in both cases, malformed escapes, strings that end inside an escape), then
// a long random stream made mostly of well-formed escapes with random content
// and some noise. Each accepted request is run through a local decoder model;
// every decoded byte is compared in order against the table or the model.
// Both channels idle at random, with some stretches at full rate.
// ============================================================================
module percent_escape_decoder_top_tb;
    import ped_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    percent_escape_decoder_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5ns i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Directed table. A row with typed set carries its decoded bytes; the
    // final one of them is marked last when the request is marked last.
    // Rows without typed set are checked against the model below.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]      in_byte;
        logic            in_last;
        logic            typed;
        logic [1:0]      n_out;
        logic [0:2][7:0] out_bytes;
    } t_row;

    localparam int unsigned N_ROWS = 24;
    localparam t_row DIR_ROWS [N_ROWS] = '{
        // plain bytes at both extremes, the second one closes a string
        '{8'h00,  1'b0, 1'b1, 2'd1, '{8'h00,  8'h00,  8'h00}},
        '{8'hFF,  1'b1, 1'b1, 2'd1, '{8'hFF,  8'h00,  8'h00}},
        // "%%" collapses to one percent
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{CH_PCT, 1'b0, 1'b1, 2'd1, '{CH_PCT, 8'h00,  8'h00}},
        // "%41" -> 'A'
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h34,  1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h31,  1'b0, 1'b1, 2'd1, '{8'h41,  8'h00,  8'h00}},
        // "%fF" -> 0xFF, mixed case digits
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h66,  1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h46,  1'b0, 1'b1, 2'd1, '{8'hFF,  8'h00,  8'h00}},
        // percent followed by a non-hex char passes both through
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h47,  1'b0, 1'b1, 2'd2, '{CH_PCT, 8'h47,  8'h00}},
        // bad second digit: percent, held digit and the char
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h39,  1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h7A,  1'b0, 1'b1, 2'd3, '{CH_PCT, 8'h39,  8'h7A}},
        // string ends right after a percent
        '{CH_PCT, 1'b1, 1'b1, 2'd1, '{CH_PCT, 8'h00,  8'h00}},
        // string ends on the first digit: percent and digit flushed
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h42,  1'b1, 1'b1, 2'd2, '{CH_PCT, 8'h42,  8'h00}},
        // "%a0" left to the model
        '{CH_PCT, 1'b0, 1'b0, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h61,  1'b0, 1'b0, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h30,  1'b0, 1'b0, 2'd0, '{8'h00,  8'h00,  8'h00}},
        // bad second digit on the closing byte: three bytes, last marked
        '{CH_PCT, 1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h46,  1'b0, 1'b1, 2'd0, '{8'h00,  8'h00,  8'h00}},
        '{8'h78,  1'b1, 1'b1, 2'd3, '{CH_PCT, 8'h46,  8'h78}}
    };

    localparam int unsigned N_RANDOM    = 270;
    localparam int unsigned DRAIN_TICKS = 16;   // margin for the output queue

    // ------------------------------------------------------------------------
    // Decoder model state and the decoded bytes still owed by the DUT
    // ------------------------------------------------------------------------
    t_phase     esc_phase;
    logic [7:0] held_char;
    logic [3:0] held_nib;
    t_out       decoded_q [$];

    bit          quiet;         // both sides run at full rate while set
    int unsigned err_cnt;
    int unsigned reqs_sent;
    int unsigned strings_ended;
    int unsigned bytes_checked;

    function automatic int unsigned pick_wait();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // Hex digit test; the low nibble of '0'..'9' is the value itself and
    // 'A'..'F' / 'a'..'f' hold the value less nine in theirs.
    function automatic bit hex_nib(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'd0;
        if (c >= CH_0 && c <= CH_9) begin
            nib = c[3:0];
            return 1'b1;
        end
        if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
            nib = NIB_10 + c[3:0] - 4'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One request through the model: advances the escape state and returns
    // the decoded bytes it produces, in order.
    function automatic void decode_step(input t_in req, ref t_out res [$]);
        logic [3:0] nib;
        logic [7:0] c;
        bit         is_hex;
        res.delete();
        c      = req.in_byte;
        is_hex = hex_nib(c, nib);
        case (esc_phase)
            PH_PCT: begin
                if (c == CH_PCT) begin
                    res.push_back(t_out'{CH_PCT, 1'b0});
                    esc_phase = PH_IDLE;
                end else if (is_hex) begin
                    held_char = c;
                    held_nib  = nib;
                    esc_phase = PH_DIGIT;
                end else begin
                    res.push_back(t_out'{CH_PCT, 1'b0});
                    res.push_back(t_out'{c, 1'b0});
                    esc_phase = PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (is_hex) begin
                    res.push_back(t_out'{{held_nib, nib}, 1'b0});
                end else begin
                    res.push_back(t_out'{CH_PCT, 1'b0});
                    res.push_back(t_out'{held_char, 1'b0});
                    res.push_back(t_out'{c, 1'b0});
                end
                esc_phase = PH_IDLE;
            end
            default: begin
                if (c == CH_PCT) begin
                    esc_phase = PH_PCT;
                end else begin
                    res.push_back(t_out'{c, 1'b0});
                    esc_phase = PH_IDLE;
                end
            end
        endcase
        // end of string: flush whatever escape is open, mark the final byte
        if (req.in_last) begin
            if (esc_phase == PH_PCT) begin
                res.push_back(t_out'{CH_PCT, 1'b0});
            end else if (esc_phase == PH_DIGIT) begin
                res.push_back(t_out'{CH_PCT, 1'b0});
                res.push_back(t_out'{held_char, 1'b0});
            end
            esc_phase = PH_IDLE;
            if (res.size() > 0) begin
                res[res.size() - 1].out_last = 1'b1;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Entered and left at a falling edge; the request is held
    // until an edge sees valid high with stall low.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_in req);
        int unsigned gap;
        gap = pick_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        reqs_sent++;
        if (req.in_last) strings_ended++;
    endtask

    // Send and queue what the model says the request decodes to.
    task automatic issue(input t_in req);
        t_out res [$];
        send_request(req);
        decode_step(req, res);
        foreach (res[k]) decoded_q.push_back(res[k]);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int unsigned v;
        v = $urandom_range(0, 15);
        if (v < 10) return CH_0 + 8'(v);
        if ($urandom_range(0, 1) != 0) return CH_UA + 8'(v - 10);
        return CH_LA + 8'(v - 10);
    endfunction

    // Mostly chars right next to the hex ranges, or a percent, or anything.
    function automatic logic [7:0] rand_near_hex();
        case ($urandom_range(0, 7))
            0:       return 8'h2F;
            1:       return 8'h3A;
            2:       return 8'h40;
            3:       return 8'h47;
            4:       return 8'h60;
            5:       return 8'h67;
            6:       return CH_PCT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stim
        t_in        req;
        t_out       res [$];
        logic [7:0] seq [$];
        int unsigned n_rand;

        err_cnt       = 0;
        reqs_sent     = 0;
        strings_ended = 0;
        bytes_checked = 0;
        quiet         = 1'b0;
        esc_phase     = PH_IDLE;
        held_char     = 8'h00;
        held_nib      = 4'h0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;

        // synchronous reset, held low, released at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < N_ROWS; r++) begin
            req.in_byte = DIR_ROWS[r].in_byte;
            req.in_last = DIR_ROWS[r].in_last;
            if (!DIR_ROWS[r].typed) begin
                issue(req);
            end else begin
                send_request(req);
                decode_step(req, res);     // keeps the model's state in step
                for (int k = 0; k < DIR_ROWS[r].n_out; k++) begin
                    decoded_q.push_back(t_out'{DIR_ROWS[r].out_bytes[k],
                        req.in_last && (k == DIR_ROWS[r].n_out - 1)});
                end
            end
        end

        // random stream: mostly well-formed escapes, mixed with noise and
        // broken escapes; any byte may close a string
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            if (n_rand % 45 == 0) quiet = ($urandom_range(0, 2) == 0);
            seq.delete();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    seq.push_back(8'($urandom_range(0, 255)));
                end
                3, 4, 5, 6: begin
                    seq.push_back(CH_PCT);
                    seq.push_back(rand_hex_char());
                    seq.push_back(rand_hex_char());
                end
                7: begin
                    seq.push_back(CH_PCT);
                    seq.push_back(CH_PCT);
                end
                8: begin
                    seq.push_back(CH_PCT);
                    seq.push_back(rand_near_hex());
                end
                default: begin
                    seq.push_back(CH_PCT);
                    seq.push_back(rand_hex_char());
                    seq.push_back(rand_near_hex());
                end
            endcase
            foreach (seq[k]) begin
                req.in_byte = seq[k];
                req.in_last = ($urandom_range(0, 7) == 0);
                issue(req);
                n_rand++;
            end
        end
        quiet = 1'b0;

        // drain: every owed byte back, then a quiet spell for strays
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        $display("%0d requests (%0d directed, %0d strings closed), %0d decoded bytes checked",
                 reqs_sent, N_ROWS, strings_ended, bytes_checked);
        if (err_cnt == 0) begin
            $display("percent_escape_decoder_top_tb: done, clean");
        end else begin
            $display("percent_escape_decoder_top_tb: done, errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: stall for a random count of cycles, then accept one
    // decoded byte with stall low.
    // ------------------------------------------------------------------------
    initial begin : drain_side
        int unsigned hold;
        i_stall = 1'b0;
        forever begin
            hold = pick_wait();
            repeat (hold) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    // ------------------------------------------------------------------------
    // Result check, field by field against the oldest owed byte
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            bytes_checked++;
            if (decoded_q.size() == 0) begin
                $error("decoded byte with none owed: out_byte=%02h out_last=%0b",
                       o_data.out_byte, o_data.out_last);
                err_cnt++;
            end else begin
                want = decoded_q.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, o_data.out_byte);
                    err_cnt++;
                end
                if (o_data.out_last !== want.out_last) begin
                    $error("out_last: expected %0b, got %0b",
                           want.out_last, o_data.out_last);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the slowest clean run is well under a tenth of this
    // ------------------------------------------------------------------------
    initial begin : watchdog
        #2ms;
        $display("percent_escape_decoder_top_tb: done, errors");
        $finish;
    end

endmodule
